### sv/salc_pkg.sv
package salc_pkg;

  localparam int MAX_SET_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int ADDR_WIDTH_DEF   = 64;
  localparam int COUNT_WIDTH_DEF  = 32;

  localparam int IN_ADDR_W  = 64;
  localparam int OUT_CNT_W  = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_MODIFY = 2'd1;

  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS       = 2'd2;

  typedef enum logic [1:0] {
    OC_HIT    = 2'd0,
    OC_MISS   = 2'd1,
    OC_EVICT  = 2'd2,
    OC_IGNORE = 2'd3
  } outcome_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_LOOK = 1'b1
  } state_t;

  typedef struct packed {
    logic load;
    logic update;
  } ctrl_cmd_t;

endpackage

### sv/set_assoc_lru_cache_sim_top.sv
// Set-associative LRU cache hit/miss counter.
// Input: pulse start with in_command and in_address while busy is low; the
// beat is taken at that edge. in_command 0 is a load or store, 1 a modify,
// 2 or 3 an instruction fetch that changes nothing.
// Output: out_valid is high for one cycle per input beat, after the access
// has passed the load registers and the result registers, with the outcome
// (hit, miss, miss with eviction or ignored), the extra-hit flag of a modify
// and the running saturating totals. The set's row is read from the tag RAM
// at the accepting edge and compared, reordered and written back in the LOOK
// state; busy is high during that state, so no new access is taken then.
// The next start may come in the cycle the result appears.
// Configuration: APB writes to set_bits (0x0), block_bits (0x4), ways_in_use
// (0x8); the user writes only while no access is in flight, unenforced here.
// Reset: rst_n low clears counters, set_bits, block_bits, per-set valid flags
// and sets ways_in_use to 1 at once; no clearing pass. Output cannot stall.
module set_assoc_lru_cache_sim_top #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF,
  parameter int ADDR_WIDTH   = salc_pkg::ADDR_WIDTH_DEF,
  parameter int COUNT_WIDTH  = salc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       in_command,
  input  logic [salc_pkg::IN_ADDR_W-1:0]   in_address,
  output logic                             out_valid,
  output logic [1:0]                       out_outcome,
  output logic                             out_second_hit,
  output logic [salc_pkg::OUT_CNT_W-1:0]   out_hits_total,
  output logic [salc_pkg::OUT_CNT_W-1:0]   out_misses_total,
  output logic [salc_pkg::OUT_CNT_W-1:0]   out_evictions_total,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [salc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [salc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [salc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);

  import salc_pkg::*;

  ctrl_cmd_t  cmd;
  logic [2:0] set_bits_r;
  logic [5:0] block_bits_r;
  logic [3:0] ways_r;
  logic [1:0] reg_idx;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= '0;
      block_bits_r <= '0;
      ways_r       <= 4'd1;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SET_BITS:   set_bits_r   <= pwdata[2:0];
        REG_BLOCK_BITS: block_bits_r <= pwdata[5:0];
        REG_WAYS:       ways_r       <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SET_BITS:   prdata = CFG_DATA_W'(set_bits_r);
      REG_BLOCK_BITS: prdata = CFG_DATA_W'(block_bits_r);
      REG_WAYS:       prdata = CFG_DATA_W'(ways_r);
      default:        prdata = '0;
    endcase
  end

  salc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  salc_datapath #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_WIDTH   (ADDR_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_command          (in_command),
    .in_address          (in_address),
    .set_bits            (set_bits_r),
    .block_bits          (block_bits_r),
    .ways_in_use         (ways_r),
    .out_valid           (out_valid),
    .out_outcome         (out_outcome),
    .out_second_hit      (out_second_hit),
    .out_hits_total      (out_hits_total),
    .out_misses_total    (out_misses_total),
    .out_evictions_total (out_evictions_total)
  );

endmodule

### sv/salc_ram.sv
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/salc_ctrl.sv
module salc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  output salc_pkg::ctrl_cmd_t   cmd
);

  import salc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    busy       = 1'b0;
    cmd.load   = 1'b0;
    cmd.update = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        busy       = 1'b1;
        cmd.update = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### sv/salc_datapath.sv
module salc_datapath #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF,
  parameter int ADDR_WIDTH   = salc_pkg::ADDR_WIDTH_DEF,
  parameter int COUNT_WIDTH  = salc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  salc_pkg::ctrl_cmd_t             cmd,
  input  logic [1:0]                      in_command,
  input  logic [salc_pkg::IN_ADDR_W-1:0]  in_address,
  input  logic [2:0]                      set_bits,
  input  logic [5:0]                      block_bits,
  input  logic [3:0]                      ways_in_use,
  output logic                            out_valid,
  output logic [1:0]                      out_outcome,
  output logic                            out_second_hit,
  output logic [salc_pkg::OUT_CNT_W-1:0]  out_hits_total,
  output logic [salc_pkg::OUT_CNT_W-1:0]  out_misses_total,
  output logic [salc_pkg::OUT_CNT_W-1:0]  out_evictions_total
);

  import salc_pkg::*;

  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
  localparam int ROW_W    = MAX_WAYS * (ADDR_WIDTH + 1);

  logic [ADDR_WIDTH-1:0] addr;
  logic [2:0]            sb_eff;
  logic [ADDR_WIDTH-1:0] addr_shr;
  logic [SET_W-1:0]      set_mask;
  logic [SET_W-1:0]      set_in;
  logic [ADDR_WIDTH-1:0] tag_in;

  logic [1:0]            cmd_r;
  logic [SET_W-1:0]      set_r;
  logic [ADDR_WIDTH-1:0] tag_r;
  logic [NUM_SETS-1:0]   row_ok_r;

  logic [ROW_W-1:0]      row_rd;
  logic [ROW_W-1:0]      row_wr;
  logic                  row_we;

  logic [MAX_WAYS-1:0]   way_vld;
  logic [ADDR_WIDTH-1:0] way_tag [MAX_WAYS];
  logic [MAX_WAYS-1:0]   new_vld;
  logic [ADDR_WIDTH-1:0] new_tag [MAX_WAYS];
  logic [MAX_WAYS-1:0]   hit_vec;
  logic [MAX_WAYS-1:0]   free_vec;
  logic [WCNT_W-1:0]     ways_eff;
  logic [WAY_W-1:0]      hit_pos;
  logic [WAY_W-1:0]      free_pos;
  logic [WAY_W-1:0]      pos;
  outcome_t              lookup_oc;
  logic                  is_acc;
  logic                  is_mod;

  logic [1:0]             hit_add;
  logic [COUNT_WIDTH:0]   hit_sum;
  logic [COUNT_WIDTH:0]   miss_sum;
  logic [COUNT_WIDTH:0]   evict_sum;
  logic [COUNT_WIDTH-1:0] hit_cnt_r;
  logic [COUNT_WIDTH-1:0] miss_cnt_r;
  logic [COUNT_WIDTH-1:0] evict_cnt_r;
  logic [COUNT_WIDTH-1:0] hit_cnt_nxt;
  logic [COUNT_WIDTH-1:0] miss_cnt_nxt;
  logic [COUNT_WIDTH-1:0] evict_cnt_nxt;

  outcome_t              outcome_r;
  outcome_t              outcome_nxt;
  logic                  second_r;
  logic                  valid_r;

  // split address into set index and tag
  always_comb begin
    addr     = in_address[ADDR_WIDTH-1:0];
    sb_eff   = (int'(set_bits) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits;
    addr_shr = addr >> block_bits;
    set_mask = SET_W'((32'd1 << sb_eff) - 32'd1);
    set_in   = addr_shr[SET_W-1:0] & set_mask;
    tag_in   = addr >> (7'(sb_eff) + 7'(block_bits));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_command;
      set_r <= set_in;
      tag_r <= tag_in;
    end
  end

  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (set_r),
    .wdata (row_wr),
    .raddr (set_in),
    .rdata (row_rd)
  );

  // compare all ways in use, then move the chosen way to the front
  always_comb begin
    if (ways_in_use == 4'd0) begin
      ways_eff = WCNT_W'(1);
    end else if (int'(ways_in_use) > MAX_WAYS) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WCNT_W'(ways_in_use);
    end

    for (int i = 0; i < MAX_WAYS; i++) begin
      way_vld[i] = row_rd[MAX_WAYS*ADDR_WIDTH + i] & row_ok_r[set_r];
      way_tag[i] = row_rd[i*ADDR_WIDTH +: ADDR_WIDTH];
      hit_vec[i]  = (i < int'(ways_eff)) && way_vld[i] && (way_tag[i] == tag_r);
      free_vec[i] = (i < int'(ways_eff)) && !way_vld[i];
    end

    hit_pos  = '0;
    free_pos = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_pos = WAY_W'(i);
      end
      if (free_vec[i]) begin
        free_pos = WAY_W'(i);
      end
    end

    if (|hit_vec) begin
      pos       = hit_pos;
      lookup_oc = OC_HIT;
    end else if (|free_vec) begin
      pos       = free_pos;
      lookup_oc = OC_MISS;
    end else begin
      pos       = WAY_W'(ways_eff - WCNT_W'(1));
      lookup_oc = OC_EVICT;
    end

    for (int k = 0; k < MAX_WAYS; k++) begin
      if (k == 0) begin
        new_vld[k] = 1'b1;
        new_tag[k] = tag_r;
      end else if (k <= int'(pos)) begin
        new_vld[k] = way_vld[k-1];
        new_tag[k] = way_tag[k-1];
      end else begin
        new_vld[k] = way_vld[k];
        new_tag[k] = way_tag[k];
      end
    end

    for (int k = 0; k < MAX_WAYS; k++) begin
      row_wr[k*ADDR_WIDTH +: ADDR_WIDTH] = new_tag[k];
      row_wr[MAX_WAYS*ADDR_WIDTH + k]    = new_vld[k];
    end
  end

  assign is_mod = (cmd_r == CMD_MODIFY);
  assign is_acc = (cmd_r == CMD_LOAD) || is_mod;
  assign row_we = cmd.update && is_acc;

  // saturating counts
  always_comb begin
    hit_add = 2'((is_acc && (lookup_oc == OC_HIT)) ? 1 : 0) + 2'(is_mod ? 1 : 0);
    hit_sum   = {1'b0, hit_cnt_r} + (COUNT_WIDTH+1)'(hit_add);
    miss_sum  = {1'b0, miss_cnt_r}
              + (COUNT_WIDTH+1)'(is_acc && (lookup_oc != OC_HIT));
    evict_sum = {1'b0, evict_cnt_r}
              + (COUNT_WIDTH+1)'(is_acc && (lookup_oc == OC_EVICT));
    hit_cnt_nxt   = hit_sum[COUNT_WIDTH]   ? '1 : hit_sum[COUNT_WIDTH-1:0];
    miss_cnt_nxt  = miss_sum[COUNT_WIDTH]  ? '1 : miss_sum[COUNT_WIDTH-1:0];
    evict_cnt_nxt = evict_sum[COUNT_WIDTH] ? '1 : evict_sum[COUNT_WIDTH-1:0];
    outcome_nxt   = is_acc ? lookup_oc : OC_IGNORE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_ok_r    <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
      valid_r     <= 1'b0;
    end else begin
      valid_r <= cmd.update;
      if (row_we) begin
        row_ok_r[set_r] <= 1'b1;
      end
      if (cmd.update) begin
        hit_cnt_r   <= hit_cnt_nxt;
        miss_cnt_r  <= miss_cnt_nxt;
        evict_cnt_r <= evict_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      outcome_r <= outcome_nxt;
      second_r  <= is_mod;
    end
  end

  assign out_valid           = valid_r;
  assign out_outcome         = outcome_r;
  assign out_second_hit      = second_r;
  assign out_hits_total      = OUT_CNT_W'(hit_cnt_r);
  assign out_misses_total    = OUT_CNT_W'(miss_cnt_r);
  assign out_evictions_total = OUT_CNT_W'(evict_cnt_r);

endmodule
